>>> sv/dsrt_pkg.sv
// Shared types, codes and calendar helpers for the date-sorted reminder table.
`timescale 1ns / 1ps
`default_nettype none

package dsrt_pkg;

    // One stored reminder; month sits in the lowest bits, the same as the stream word.
    typedef struct packed {
        logic [15:0] tag;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
    } t_entry;

    localparam int ENTRY_W   = $bits(t_entry);
    localparam int KEY_W     = 20;
    localparam int POS_W     = 6;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 48;

    // Month codes and calendar lengths.
    localparam logic [3:0] MONTH_LIST      = 4'd0;
    localparam logic [3:0] MONTH_FEB       = 4'd2;
    localparam logic [3:0] MONTH_APR       = 4'd4;
    localparam logic [3:0] MONTH_JUN       = 4'd6;
    localparam logic [3:0] MONTH_SEP       = 4'd9;
    localparam logic [3:0] MONTH_NOV       = 4'd11;
    localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
    localparam logic [4:0] DAYS_FEB        = 5'd28;
    localparam logic [4:0] DAYS_SHORT      = 5'd30;
    localparam logic [4:0] DAYS_LONG       = 5'd31;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_BAD_MONTH = 3'd1,
        ST_BAD_DAY   = 3'd2,
        ST_FULL      = 3'd3,
        ST_LISTED    = 3'd4,
        ST_EMPTY     = 3'd5
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CMP,
        S_INS,
        S_EMIT,
        S_LIST
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_req;
        logic    do_cmp;
        logic    do_ins;
        logic    emit_one;
        logic    emit_list;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic month_zero;
        logic bad_month;
        logic bad_day;
        logic full;
        logic empty;
        logic list_last;
        logic out_free;
    } t_dp_sts;

    // Number of days in a month; months outside 1..12 are caught before this matters.
    function automatic logic [4:0] days_in(input logic [3:0] month);
        logic [4:0] days;
        days = DAYS_LONG;
        if (month == MONTH_FEB) begin
            days = DAYS_FEB;
        end else if (month == MONTH_APR || month == MONTH_JUN ||
                     month == MONTH_SEP || month == MONTH_NOV) begin
            days = DAYS_SHORT;
        end
        return days;
    endfunction

    // Sort key: month, day, hour, minute from most to least significant.
    function automatic logic [KEY_W-1:0] key_of(input t_entry e);
        return {e.month, e.day, e.hour, e.minute};
    endfunction

endpackage

`default_nettype wire

>>> sv/date_sorted_reminder_table.sv
// Top level of the date-sorted reminder table: controller, datapath and checks.
//
// Usage: each request on the slave stream is one reminder command. Month 1..12
// adds the reminder, kept sorted by month, day, hour and minute; month 0 lists
// all stored reminders in order; other months, bad days or a full table give
// one error result. Every result leaves on the master stream with the status
// code in tuser and tlast set on the final result of its request.
// A request is taken in the idle state and decoded in the cycle after; an
// error or empty-list result is then registered in the result state, while
// an add first compares every cell against the new key and then shifts the
// cell chain before its result is registered. A listing gives one entry per
// cycle while the receiver takes results, by rotating the chain through slot 0.
// One request is handled at a time.
// Reset empties the table; no clearing pass is needed. A stalled receiver
// holds the result register and the controller waits; the next request is
// taken while the last result of the previous one still waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module date_sorted_reminder_table
    import dsrt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // month[3:0], day[8:4], hour[13:9], minute[19:14], tag[35:20], zero pad[39:36]
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // out_month[3:0], out_day[8:4], out_hour[13:9], out_minute[19:14],
    // out_tag[35:20], position[41:36], zero pad[47:42]
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // status[2:0]
    output logic [2:0]                 o_m_tuser,
    output logic                       o_m_tlast
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_state  w_state;
    t_entry  w_req;

    assign w_req = t_entry'(i_s_tdata[ENTRY_W-1:0]);

    // Sequencer for decode, compare, insert and listing.
    dsrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    // Cell chain and result register.
    dsrt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // A full table is never reported as empty.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.full |-> !w_sts.empty)
        else $error("table reports full and empty together");

    // An insert is always followed by its stored result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state == S_INS) |=> (w_state == S_EMIT))
        else $error("insert not followed by result");

    // A single result leaves as the final result of its request.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_one |=> (o_m_tvalid && o_m_tlast && w_state == S_IDLE))
        else $error("single result not marked last");

    // The last listed entry ends the listing and returns to idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit_list && w_sts.list_last) |=>
            (o_m_tvalid && o_m_tlast && o_m_tuser == ST_LISTED && w_state == S_IDLE))
        else $error("listing did not end on last entry");

endmodule

`default_nettype wire

>>> sv/dsrt_ctrl.sv
// Controller state machine for the date-sorted reminder table.
`timescale 1ns / 1ps
`default_nettype none

module dsrt_ctrl
    import dsrt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd,
    output t_state       o_state
);

    t_state  r_state, n_state;
    t_status r_status, n_status;

    // State and pending status registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_STORED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // Next state and datapath commands; no request is taken during reset.
    always_comb begin
        n_state          = r_state;
        n_status         = r_status;
        o_cmd            = '0;
        o_cmd.status     = r_status;
        o_s_tready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_sts.month_zero) begin
                    if (i_sts.empty) begin
                        n_status = ST_EMPTY;
                        n_state  = S_EMIT;
                    end else begin
                        n_state  = S_LIST;
                    end
                end else if (i_sts.bad_month) begin
                    n_status = ST_BAD_MONTH;
                    n_state  = S_EMIT;
                end else if (i_sts.bad_day) begin
                    n_status = ST_BAD_DAY;
                    n_state  = S_EMIT;
                end else if (i_sts.full) begin
                    n_status = ST_FULL;
                    n_state  = S_EMIT;
                end else begin
                    n_status = ST_STORED;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.do_cmp = 1'b1;
                n_state      = S_INS;
            end
            S_INS: begin
                o_cmd.do_ins = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_one = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_list = 1'b1;
                    if (i_sts.list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

>>> sv/dsrt_dp.sv
// Datapath of the date-sorted reminder table: entry cell chain, checks and result register.
`timescale 1ns / 1ps
`default_nettype none

module dsrt_dp
    import dsrt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_entry                i_req,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_m_tready,
    output logic                       o_m_tvalid,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic [2:0]                 o_m_tuser,
    output logic                       o_m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_entry              r_req;
    t_entry              r_cells [CAPACITY];
    t_entry              n_cells [CAPACITY];
    t_entry              w_up    [CAPACITY];
    t_entry              w_dn    [CAPACITY];
    logic [CAPACITY-1:0] r_lt;
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_prev_lt;
    logic [CAPACITY-1:0] w_take;
    logic [CAPACITY-1:0] w_shift;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    w_pos;
    logic                w_list_last;

    logic                r_out_valid;
    t_entry              r_out_entry;
    t_status             r_out_status;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_out_last;

    // Neighbor taps of each cell; the chain ends take the request or hold.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_dn[g]      = r_req;
            assign w_prev_lt[g] = 1'b1;
        end else begin : g_body
            assign w_dn[g]      = r_cells[g-1];
            assign w_prev_lt[g] = r_lt[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_up[g] = r_cells[g];
        end else begin : g_inner
            assign w_up[g] = r_cells[g+1];
        end
        // Each cell compares its own key against the request.
        assign w_lt[g]    = (CW'(g) < r_count) && (key_of(r_cells[g]) < key_of(r_req));
        // Sorted chain: the lt bits form a thermometer, the new entry goes at its edge.
        assign w_take[g]  = w_prev_lt[g] & ~r_lt[g];
        assign w_shift[g] = ~w_prev_lt[g] && (CW'(g) <= r_count);
    end

    // Slot of the inserted entry from the one-hot take vector.
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_take[i]) begin
                w_pos = w_pos | POS_W'(i);
            end
        end
    end

    // Next cell contents: insert with shift down, or rotate by one while listing.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
            if (i_cmd.do_ins) begin
                if (w_take[i]) begin
                    n_cells[i] = r_req;
                end else if (w_shift[i]) begin
                    n_cells[i] = w_dn[i];
                end
            end else if (i_cmd.emit_list) begin
                if (CW'(i + 1) == r_count) begin
                    n_cells[i] = r_cells[0];
                end else if (CW'(i + 1) < r_count) begin
                    n_cells[i] = w_up[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
    end

    // Request, compare vector and insert slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
            r_pos <= '0;
        end else if (i_cmd.do_ins) begin
            r_pos <= w_pos;
        end
        if (i_cmd.do_cmp) begin
            r_lt <= w_lt;
        end
    end

    // Entry count and listing index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.do_ins) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load_req) begin
                r_idx <= '0;
            end else if (i_cmd.emit_list) begin
                r_idx <= w_list_last ? '0 : r_idx + CW'(1);
            end
        end
    end

    assign w_list_last = (r_idx + CW'(1)) == r_count;

    // Checks reported to the controller.
    always_comb begin
        o_sts.month_zero = (r_req.month == MONTH_LIST);
        o_sts.bad_month  = (r_req.month > MONTHS_PER_YEAR);
        o_sts.bad_day    = (r_req.day == 5'd0) || (r_req.day > days_in(r_req.month));
        o_sts.full       = (r_count == CW'(CAPACITY));
        o_sts.empty      = (r_count == '0);
        o_sts.list_last  = w_list_last;
        o_sts.out_free   = !r_out_valid || i_m_tready;
    end

    // Result register; a new result loads when the slot is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_one || i_cmd.emit_list) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_one) begin
            r_out_entry  <= r_req;
            r_out_status <= i_cmd.status;
            r_out_pos    <= r_pos;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_list) begin
            r_out_entry  <= r_cells[0];
            r_out_status <= ST_LISTED;
            r_out_pos    <= POS_W'(r_idx);
            r_out_last   <= w_list_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - POS_W - ENTRY_W){1'b0}}, r_out_pos, r_out_entry};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
